// ===== rtl/u8l1_pkg.sv =====
// shared constants, types and the lead-byte length decode for the utf-8 to latin-1 escaper
// no dependencies
package u8l1_pkg;

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_NBSP   = 8'hA0;
  localparam logic [4:0] OCT_HIGH  = 5'b00110;

  localparam int unsigned OUT_MAX  = 4;
  localparam int unsigned HOLD_MAX = 3;

  // unfinished sequence held between items
  typedef struct packed {
    logic [1:0]                   fill;
    logic [HOLD_MAX-1:0][7:0]     bytes;
  } held_t;

  // result of one item
  typedef struct packed {
    logic [2:0]                   count;
    logic [OUT_MAX-1:0][7:0]      bytes;
    logic [2:0]                   drops;
  } emit_t;

  // sequence length from a lead byte, zero when it is no lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ===== rtl/u8l1_if.sv =====
// valid/ready channel interfaces for the input bytes and the escaped results
// depends on nothing
interface u8l1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface u8l1_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  emit_count;
  logic [7:0]  emit_byte_a;
  logic [7:0]  emit_byte_b;
  logic [7:0]  emit_byte_c;
  logic [7:0]  emit_byte_d;
  logic [31:0] dropped_total;
  logic        string_done;

  modport source (output valid, output emit_count, output emit_byte_a, output emit_byte_b,
                  output emit_byte_c, output emit_byte_d, output dropped_total,
                  output string_done, input ready);
  modport sink   (input valid, input emit_count, input emit_byte_a, input emit_byte_b,
                  input emit_byte_c, input emit_byte_d, input dropped_total,
                  input string_done, output ready);
endinterface

// ===== rtl/u8l1_step.sv =====
// combinational decode of one byte against the held sequence: escaped bytes, drops, next hold
// depends on u8l1_pkg
module u8l1_step import u8l1_pkg::*; (
  input  logic [7:0] in_byte,
  input  logic       text_end,
  input  held_t      held,
  output held_t      held_next,
  output emit_t      result
);

  always_comb begin
    logic [6:0][7:0]         run_buf;
    logic [2:0]              run_n;
    logic [2:0]              lead_len;
    logic [2:0]              fill_inc;
    logic [2:0]              pos;
    logic [2:0]              cnt;
    logic [2:0]              drops;
    logic [OUT_MAX-1:0][7:0] slots;
    logic [2:0]              len;
    logic [20:0]             cp;
    logic [2:0]              adv;
    logic                    is_cp;
    logic                    low;
    logic [3:0][7:0]         cp_bytes;
    logic [2:0]              cp_len;

    held_next = held;
    run_buf   = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < {1'b0, held.fill}) begin
        run_buf[k] = held.bytes[k];
      end else if (3'(k) == {1'b0, held.fill}) begin
        run_buf[k] = in_byte;
      end
    end

    // pick the run to decode, or hold the byte
    lead_len = seq_len(held.bytes[0]);
    fill_inc = {1'b0, held.fill} + 3'd1;
    run_n    = 3'd0;
    if (text_end) begin
      run_n     = fill_inc;
      held_next = '0;
    end else if (held.fill == 2'd0) begin
      if (seq_len(in_byte) != 3'd0) begin
        held_next.fill     = 2'd1;
        held_next.bytes[0] = in_byte;
      end else begin
        run_n = 3'd1;
      end
    end else if (fill_inc >= lead_len) begin
      run_n     = fill_inc;
      held_next = '0;
    end else begin
      held_next.bytes[held.fill] = in_byte;
      held_next.fill             = fill_inc[1:0];
    end

    // walk the run, at most four starts
    pos   = 3'd0;
    cnt   = 3'd0;
    drops = 3'd0;
    slots = '0;
    for (int i = 0; i < 4; i++) begin
      is_cp    = 1'b0;
      low      = 1'b0;
      cp       = '0;
      adv      = 3'd1;
      cp_len   = 3'd0;
      cp_bytes = '0;
      len      = seq_len(run_buf[i]);
      if (pos == 3'(i) && 3'(i) < run_n) begin
        if (!run_buf[i][7]) begin
          cp    = {13'd0, run_buf[i]};
          is_cp = 1'b1;
        end else if (len == 3'd2 && 3'(i + 1) < run_n) begin
          cp    = {10'd0, run_buf[i][4:0], run_buf[i+1][5:0]};
          adv   = 3'd2;
          is_cp = 1'b1;
        end else if (len == 3'd3 && 3'(i + 2) < run_n) begin
          cp    = {5'd0, run_buf[i][3:0], run_buf[i+1][5:0], run_buf[i+2][5:0]};
          adv   = 3'd3;
          is_cp = 1'b1;
        end else if (len == 3'd4 && 3'(i + 3) < run_n) begin
          cp    = {run_buf[i][2:0], run_buf[i+1][5:0], run_buf[i+2][5:0], run_buf[i+3][5:0]};
          adv   = 3'd4;
          is_cp = 1'b1;
        end else begin
          drops = drops + 3'd1;
        end

        low = (cp[20:8] == 13'd0);
        if (is_cp) begin
          if (low && cp[7:0] >= CH_SPACE && cp[7:0] < CH_DEL) begin
            if (cp[7:0] == CH_LPAREN || cp[7:0] == CH_RPAREN || cp[7:0] == CH_BSL) begin
              cp_bytes[0] = CH_BSL;
              cp_bytes[1] = cp[7:0];
              cp_len      = 3'd2;
            end else begin
              cp_bytes[0] = cp[7:0];
              cp_len      = 3'd1;
            end
          end else if (low && cp[7:0] >= CH_NBSP) begin
            cp_bytes[0] = CH_BSL;
            cp_bytes[1] = {OCT_HIGH, 1'b0, cp[7:6]};
            cp_bytes[2] = {OCT_HIGH, cp[5:3]};
            cp_bytes[3] = {OCT_HIGH, cp[2:0]};
            cp_len      = 3'd4;
          end else if (low && (cp[7:0] == CH_TAB || cp[7:0] == CH_LF || cp[7:0] == CH_CR)) begin
            cp_len = 3'd0;
          end else begin
            drops = drops + 3'd1;
          end
        end

        // append, capped at four bytes
        for (int j = 0; j < 4; j++) begin
          if (3'(j) < cp_len && cnt < 3'(OUT_MAX)) begin
            slots[cnt[1:0]] = cp_bytes[j];
            cnt             = cnt + 3'd1;
          end
        end
        pos = pos + adv;
      end
    end

    result.count = cnt;
    result.bytes = slots;
    result.drops = drops;
  end

endmodule

// ===== rtl/utf8_to_latin1_pdf_escape_unit.sv =====
// top level: utf-8 byte stream in, escaped latin-1 bytes and drop count out
// the result of each accepted item is registered; throughput 1 item per cycle while out_ch is not stalled
// the held-sequence state and the drop counter update at the accept edge, so the
// next byte can follow at once; the result register is the only pipeline stage
// reset (synchronous rst): held sequence cleared, drop count zero, no result pending
// depends on u8l1_pkg, u8l1_if, u8l1_step
module utf8_to_latin1_pdf_escape_unit import u8l1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u8l1_in_if.sink     in_ch,
  u8l1_out_if.source  out_ch
);

  // state carried between items
  held_t       held;
  held_t       held_next;
  logic [31:0] dropped_count;

  // result register
  logic        out_valid;
  logic [2:0]  out_count;
  logic [OUT_MAX-1:0][7:0] out_bytes;
  logic        out_done;

  emit_t       step_result;
  logic        accept;

  // a new item enters whenever the result register is empty or draining this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  u8l1_step u_step (
    .in_byte   (in_ch.in_byte),
    .text_end  (in_ch.text_end),
    .held      (held),
    .held_next (held_next),
    .result    (step_result)
  );

  // held sequence and running drop count
  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      dropped_count <= '0;
    end else if (accept) begin
      held          <= held_next;
      dropped_count <= dropped_count + 32'(step_result.drops);
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with each item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_count <= step_result.count;
      out_bytes <= step_result.bytes;
      out_done  <= in_ch.text_end;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.emit_count    = out_count;
  assign out_ch.emit_byte_a   = out_bytes[0];
  assign out_ch.emit_byte_b   = out_bytes[1];
  assign out_ch.emit_byte_c   = out_bytes[2];
  assign out_ch.emit_byte_d   = out_bytes[3];
  // the counter moves only with an accept, which also reloads the result
  assign out_ch.dropped_total = dropped_count;
  assign out_ch.string_done   = out_done;

  // a pending result never claims more than four bytes
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count <= 3'(OUT_MAX)))
    else $error("result byte count above four");

  // anything held is a lead still short of its full length
  a_held_lead: assert property (@(posedge clk) disable iff (rst)
    (held.fill != 2'd0) |-> (seq_len(held.bytes[0]) > {1'b0, held.fill}))
    else $error("held bytes do not form an unfinished sequence");

  // the end of a string leaves nothing held
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.text_end) |=> (held.fill == 2'd0))
    else $error("held sequence survives end of string");

  // the drop count moves only on an accepted item
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(accept)) |-> $stable(dropped_count))
    else $error("drop count changed without an item");

endmodule
